/* src/pwb_pkg.sv */
package pwb_pkg;

  localparam int unsigned RingW    = 24;
  localparam int unsigned RateW    = 20;
  localparam int unsigned SizeW    = 24;
  localparam int unsigned WaitW    = 28;
  localparam int unsigned CodeW    = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned DvdW     = SizeW + 1;
  localparam int unsigned PcW      = 5;

  localparam logic [RingW-1:0] RingReset = 24'd65536;
  localparam logic [RateW-1:0] RateReset = 20'd320;

  // floor(n / 3) = (n * Third) >> ThirdShift for any 24-bit n
  localparam logic [RingW-1:0] Third      = 24'hAAAAAB;
  localparam int unsigned      ThirdShift = 25;
  localparam logic [28:0]      WaitKnee   = 29'd100;

  typedef enum logic [CodeW-1:0] {
    EV_TOO_LONG = 2'd0,
    EV_WAIT     = 2'd1,
    EV_PROMISE  = 2'd2,
    EV_NONE     = 2'd3
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RING_SIZE = 1'd0,
    REG_RATE      = 1'd1
  } reg_e;

  typedef enum logic [3:0] {
    OP_WAIT_IN,
    OP_NOP,
    OP_JMP,
    OP_EMIT,
    OP_LARGEST,
    OP_DIV,
    OP_HOLD,
    OP_MINW,
    OP_SCALE
  } op_e;

  typedef enum logic [1:0] {
    C_FITS_THIRD,
    C_FITS_FREE,
    C_NO_WAIT,
    C_NO_PROMISE
  } cond_e;

  typedef enum logic [1:0] {
    S_EXCESS,
    S_USED,
    S_FILL
  } src_e;

  typedef enum logic [2:0] {
    E_FORCE,
    E_REJECT,
    E_WAIT,
    E_PROMISE,
    E_NONE
  } emit_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    src_e           src;
    emit_e          emit;
    logic [PcW-1:0] target;
  } ctrl_t;

  localparam logic [PcW-1:0] StepIdle    = 5'd0;
  localparam logic [PcW-1:0] StepLargest = 5'd4;
  localparam logic [PcW-1:0] StepAccept  = 5'd11;
  localparam logic [PcW-1:0] StepPromise = 5'd15;
  localparam logic [PcW-1:0] StepNone    = 5'd17;

  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t c;
    c = '{op: OP_NOP, cond: C_FITS_THIRD, src: S_EXCESS, emit: E_NONE, target: StepIdle};
    case (pc)
      5'd0:  c.op = OP_WAIT_IN;
      5'd1:  c.op = OP_NOP;
      5'd2:  begin c.op = OP_JMP; c.cond = C_FITS_THIRD; c.target = StepLargest; end
      5'd3:  begin c.op = OP_EMIT; c.emit = E_FORCE; c.target = StepIdle; end
      5'd4:  c.op = OP_LARGEST;
      5'd5:  begin c.op = OP_JMP; c.cond = C_FITS_FREE; c.target = StepAccept; end
      5'd6:  begin c.op = OP_DIV; c.src = S_EXCESS; end
      5'd7:  c.op = OP_HOLD;
      5'd8:  begin c.op = OP_DIV; c.src = S_USED; end
      5'd9:  c.op = OP_MINW;
      5'd10: begin c.op = OP_EMIT; c.emit = E_REJECT; c.target = StepIdle; end
      5'd11: begin c.op = OP_JMP; c.cond = C_NO_WAIT; c.target = StepPromise; end
      5'd12: begin c.op = OP_DIV; c.src = S_FILL; end
      5'd13: c.op = OP_SCALE;
      5'd14: begin c.op = OP_EMIT; c.emit = E_WAIT; c.target = StepPromise; end
      5'd15: begin c.op = OP_JMP; c.cond = C_NO_PROMISE; c.target = StepNone; end
      5'd16: begin c.op = OP_EMIT; c.emit = E_PROMISE; c.target = StepNone; end
      5'd17: begin c.op = OP_EMIT; c.emit = E_NONE; c.target = StepIdle; end
      default: begin c.op = OP_JMP; c.cond = C_NO_PROMISE; c.target = StepIdle; end
    endcase
    return c;
  endfunction

endpackage

/* src/playback_write_backpressure.sv */
// Paths: a write longer than a third of the ring is rejected without a division; the accept
// path runs a wait check, and a no-fit reject runs two divisions before its result.
// Requests: one at a time; the next request is taken only after the last one's result is
// issued, as set by the sequencer program and the 25-step serial divider (up to two
// divisions per request); a stalled result adds its stall.
// Reset: asynchronous, active low; registers load 65536 and 320, history clears.
module playback_write_backpressure (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pwb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pwb_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pwb_pkg::SizeW-1:0]     write_size_i,
  input  logic [pwb_pkg::SizeW-1:0]     free_space_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          accepted_o,
  output logic                          event_valid_o,
  output logic [pwb_pkg::CodeW-1:0]     event_code_o,
  output logic [pwb_pkg::WaitW-1:0]     wait_ms_o,
  output logic                          last_result_o
);

  localparam int unsigned SizeW = pwb_pkg::SizeW;
  localparam int unsigned RingW = pwb_pkg::RingW;
  localparam int unsigned RateW = pwb_pkg::RateW;
  localparam int unsigned WaitW = pwb_pkg::WaitW;
  localparam int unsigned DvdW  = pwb_pkg::DvdW;
  localparam int unsigned PcW   = pwb_pkg::PcW;

  pwb_pkg::ctrl_t ctrl;

  logic [PcW-1:0]        pc_q, pc_d;
  logic [RingW-1:0]      ring_q;
  logic [RateW-1:0]      rate_q;
  logic [RingW-1:0]      third_q;
  logic [2*RingW-1:0]    third_prod;
  logic [SizeW-1:0]      wr_q, wr_d, fr_q, fr_d;
  logic [SizeW-1:0]      largest_q, largest_d;
  pwb_pkg::event_e       last_ev_q, last_ev_d;
  logic [WaitW-1:0]      last_wait_q, last_wait_d;
  logic [WaitW-1:0]      w_q, w_d;
  logic [DvdW-1:0]       t_q, t_d, a_q, a_d;
  logic                  emitted_q, emitted_d;
  logic                  div_run_q, div_run_d;

  logic                  div_start, div_done;
  logic [DvdW-1:0]       div_dvd, div_quot;
  logic [RateW-1:0]      rate_eff;
  logic [SizeW-1:0]      used;
  logic [SizeW+1:0]      largest3;
  logic                  promise_cond, cond_hit;
  logic [DvdW-1:0]       min_t;
  logic [DvdW+3:0]       w10_min, w10_t;
  logic [DvdW+3:0]       w_scaled;

  logic                  out_free, emit_fire;
  logic                  out_valid_q;
  logic                  o_acc, o_ev, o_last;
  pwb_pkg::event_e       o_code;
  logic [WaitW-1:0]      o_wait;

  assign ctrl        = pwb_pkg::ucode(pc_q);
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (ctrl.op == pwb_pkg::OP_WAIT_IN);

  assign rate_eff     = (rate_q == '0) ? RateW'(1) : rate_q;
  assign used         = (fr_q <= ring_q) ? ring_q - fr_q : '0;
  assign largest3     = {1'b0, largest_q, 1'b0} + {2'b00, largest_q};
  assign promise_cond = fr_q > (ring_q >> 1);
  assign third_prod   = ring_q * pwb_pkg::Third;

  always_comb begin
    case (ctrl.cond)
      pwb_pkg::C_FITS_THIRD: cond_hit = wr_q <= third_q;
      pwb_pkg::C_FITS_FREE:  cond_hit = wr_q <= fr_q;
      pwb_pkg::C_NO_WAIT:    cond_hit = {2'b00, fr_q} > largest3;
      pwb_pkg::C_NO_PROMISE: cond_hit = !promise_cond;
      default:               cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    case (ctrl.src)
      pwb_pkg::S_EXCESS: div_dvd = DvdW'(wr_q - fr_q);
      pwb_pkg::S_USED:   div_dvd = DvdW'(used);
      pwb_pkg::S_FILL:   div_dvd = DvdW'(used) + DvdW'(wr_q);
      default:           div_dvd = '0;
    endcase
  end

  assign min_t    = (a_q < t_q) ? a_q : t_q;
  assign w10_min  = ({4'b0, min_t} << 3) + ({4'b0, min_t} << 1);
  assign w10_t    = ({4'b0, t_q} << 3) + ({4'b0, t_q} << 1);
  assign w_scaled = (w10_t > pwb_pkg::WaitKnee) ? (w10_t >> 2) + (w10_t >> 2 << 1) : w10_t;

  pwb_div #(
    .DvdW (DvdW),
    .DvsW (RateW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (rate_eff),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    pc_d        = pc_q;
    wr_d        = wr_q;
    fr_d        = fr_q;
    largest_d   = largest_q;
    last_ev_d   = last_ev_q;
    last_wait_d = last_wait_q;
    w_d         = w_q;
    t_d         = t_q;
    a_d         = a_q;
    emitted_d   = emitted_q;
    div_run_d   = div_run_q;
    div_start   = 1'b0;
    emit_fire   = 1'b0;
    o_acc       = 1'b1;
    o_ev        = 1'b0;
    o_code      = pwb_pkg::EV_NONE;
    o_wait      = '0;
    o_last      = 1'b1;
    case (ctrl.op)
      pwb_pkg::OP_WAIT_IN: begin
        if (in_valid_i) begin
          wr_d      = write_size_i;
          fr_d      = free_space_i;
          emitted_d = 1'b0;
          pc_d      = pc_q + PcW'(1);
        end
      end
      pwb_pkg::OP_JMP: pc_d = cond_hit ? ctrl.target : pc_q + PcW'(1);
      pwb_pkg::OP_LARGEST: begin
        if (wr_q > largest_q) largest_d = wr_q;
        pc_d = pc_q + PcW'(1);
      end
      pwb_pkg::OP_DIV: begin
        if (!div_run_q) begin
          div_start = 1'b1;
          div_run_d = 1'b1;
        end else if (div_done) begin
          div_run_d = 1'b0;
          t_d       = div_quot;
          pc_d      = pc_q + PcW'(1);
        end
      end
      pwb_pkg::OP_HOLD: begin
        a_d  = t_q + DvdW'(1);
        pc_d = pc_q + PcW'(1);
      end
      pwb_pkg::OP_MINW: begin
        w_d  = w10_min[WaitW-1:0];
        pc_d = pc_q + PcW'(1);
      end
      pwb_pkg::OP_SCALE: begin
        w_d  = w_scaled[WaitW-1:0];
        pc_d = pc_q + PcW'(1);
      end
      pwb_pkg::OP_EMIT: begin
        if (out_free) begin
          pc_d = ctrl.target;
          case (ctrl.emit)
            pwb_pkg::E_FORCE: begin
              emit_fire   = 1'b1;
              o_acc       = 1'b0;
              o_ev        = 1'b1;
              o_code      = pwb_pkg::EV_TOO_LONG;
              last_ev_d   = pwb_pkg::EV_TOO_LONG;
              last_wait_d = '0;
            end
            pwb_pkg::E_REJECT: begin
              emit_fire = 1'b1;
              o_acc     = 1'b0;
              if (!(last_ev_q == pwb_pkg::EV_TOO_LONG && last_wait_q == w_q)) begin
                o_ev        = 1'b1;
                o_code      = pwb_pkg::EV_TOO_LONG;
                o_wait      = w_q;
                last_ev_d   = pwb_pkg::EV_TOO_LONG;
                last_wait_d = w_q;
              end
            end
            pwb_pkg::E_WAIT: begin
              if (!(last_ev_q == pwb_pkg::EV_WAIT && last_wait_q == w_q)) begin
                emit_fire   = 1'b1;
                emitted_d   = 1'b1;
                o_ev        = 1'b1;
                o_code      = pwb_pkg::EV_WAIT;
                o_wait      = w_q;
                o_last      = !promise_cond;
                last_ev_d   = pwb_pkg::EV_WAIT;
                last_wait_d = w_q;
              end
            end
            pwb_pkg::E_PROMISE: begin
              if (!(last_ev_q == pwb_pkg::EV_PROMISE && last_wait_q == '0)) begin
                emit_fire   = 1'b1;
                emitted_d   = 1'b1;
                o_ev        = 1'b1;
                o_code      = pwb_pkg::EV_PROMISE;
                last_ev_d   = pwb_pkg::EV_PROMISE;
                last_wait_d = '0;
              end
            end
            pwb_pkg::E_NONE: emit_fire = !emitted_q;
            default: emit_fire = 1'b0;
          endcase
        end
      end
      default: pc_d = pc_q + PcW'(1);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= pwb_pkg::StepIdle;
      ring_q      <= pwb_pkg::RingReset;
      rate_q      <= pwb_pkg::RateReset;
      largest_q   <= '0;
      last_ev_q   <= pwb_pkg::EV_NONE;
      last_wait_q <= '0;
      emitted_q   <= 1'b0;
      div_run_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      largest_q   <= largest_d;
      last_ev_q   <= last_ev_d;
      last_wait_q <= last_wait_d;
      emitted_q   <= emitted_d;
      div_run_q   <= div_run_d;
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (pwb_pkg::reg_e'(cfg_index_i))
          pwb_pkg::REG_RING_SIZE: ring_q <= cfg_data_i[RingW-1:0];
          pwb_pkg::REG_RATE:      rate_q <= cfg_data_i[RateW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    third_q <= RingW'(third_prod >> pwb_pkg::ThirdShift);
    wr_q    <= wr_d;
    fr_q    <= fr_d;
    w_q     <= w_d;
    t_q     <= t_d;
    a_q     <= a_d;
    if (emit_fire) begin
      accepted_o    <= o_acc;
      event_valid_o <= o_ev;
      event_code_o  <= o_code;
      wait_ms_o     <= o_wait;
      last_result_o <= o_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/pwb_div.sv */
module pwb_div #(
  parameter int unsigned DvdW = pwb_pkg::DvdW,
  parameter int unsigned DvsW = pwb_pkg::RateW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DvdW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DvdW-1:0] quo_q, quo_d;
  logic [DvsW-1:0] rem_q, rem_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [DvsW:0]   trial;
  logic            ge;

  assign trial = {rem_q, quo_q[DvdW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DvdW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DvsW'(trial - {1'b0, dvs_q}) : trial[DvsW-1:0];
      quo_d = {quo_q[DvdW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* src/pwb_chk.sv */
module pwb_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      accepted_o,
  input logic                      event_valid_o,
  input logic [pwb_pkg::CodeW-1:0] event_code_o,
  input logic [pwb_pkg::WaitW-1:0] wait_ms_o,
  input logic                      last_result_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_code_o) && $stable(wait_ms_o))
    else $error("result changed while stalled");

  a_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !event_valid_o |-> event_code_o == pwb_pkg::EV_NONE && wait_ms_o == '0)
    else $error("empty result carries event data");

  a_reject_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> last_result_o
      && (event_code_o == pwb_pkg::EV_TOO_LONG || event_code_o == pwb_pkg::EV_NONE))
    else $error("rejected request with bad result");

  a_accept_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> event_code_o != pwb_pkg::EV_TOO_LONG
      && (event_code_o != pwb_pkg::EV_PROMISE || (wait_ms_o == '0 && last_result_o)))
    else $error("accepted request with bad event");

endmodule

bind playback_write_backpressure pwb_chk u_pwb_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .accepted_o    (accepted_o),
  .event_valid_o (event_valid_o),
  .event_code_o  (event_code_o),
  .wait_ms_o     (wait_ms_o),
  .last_result_o (last_result_o)
);
